// ----- rtl/core/mer_pkg.sv -----
// ----------------------------------------------------------------------------
// mer_pkg: shared definitions for the multichannel echo ranging block
// Action codes, channel mode codes, result status codes, field widths and
// the packed result record used between the compute and output stages.
// ----------------------------------------------------------------------------
package mer_pkg;

	// Field widths of the transaction ports.
	localparam int ACT_W   = 3;
	localparam int ID_W    = 3;
	localparam int STAT_W  = 2;
	localparam int DIST_W  = 18;
	localparam int PULSE_W = 20;
	localparam int TIME_W  = 32;
	localparam int CNT_W   = 32;
	localparam int TMO_W   = 20;
	localparam int MODE_W  = 3;

	// Input actions.
	localparam logic [ACT_W-1:0] ACT_TICK  = 3'd0;
	localparam logic [ACT_W-1:0] ACT_EDGE  = 3'd1;
	localparam logic [ACT_W-1:0] ACT_START = 3'd2;
	localparam logic [ACT_W-1:0] ACT_LATCH = 3'd3;
	localparam logic [ACT_W-1:0] ACT_READ  = 3'd4;
	localparam logic [ACT_W-1:0] ACT_CLEAR = 3'd5;

	// Per-channel measurement modes.
	localparam logic [MODE_W-1:0] M_IDLE  = 3'd0;
	localparam logic [MODE_W-1:0] M_WRISE = 3'd1;
	localparam logic [MODE_W-1:0] M_WFALL = 3'd2;
	localparam logic [MODE_W-1:0] M_DONE  = 3'd3;
	localparam logic [MODE_W-1:0] M_TMO   = 3'd4;
	localparam logic [MODE_W-1:0] M_FAULT = 3'd5;

	// Result status codes.
	localparam logic [STAT_W-1:0] S_VALID = 2'd0;
	localparam logic [STAT_W-1:0] S_TMO   = 2'd1;
	localparam logic [STAT_W-1:0] S_FAULT = 2'd2;

	// Reset value of the timeout register in microseconds.
	localparam logic [TMO_W-1:0] TIMEOUT_RST = 20'd25000;

	// Largest pulse width; also the reset value of the running minimum.
	localparam logic [PULSE_W-1:0] PULSE_MAX = {PULSE_W{1'b1}};

	// distance = floor(pulse * 1715 / 10000) = floor(pulse * 343 / 2000),
	// computed as (pulse * DIST_MULT) >> DIST_SHIFT with
	// DIST_MULT = ceil(343 * 2^32 / 2000). Exact for every 20-bit pulse.
	localparam int DIST_MULT_W = 30;
	localparam int DIST_SHIFT  = 32;
	localparam logic [DIST_MULT_W-1:0] DIST_MULT = 30'd736586892;

	// One result transaction.
	typedef struct packed {
		logic [ID_W-1:0]    channel_id;
		logic [STAT_W-1:0]  status;
		logic [DIST_W-1:0]  distance_mm;
		logic [CNT_W-1:0]   sample_count;
		logic [PULSE_W-1:0] min_pulse;
		logic [PULSE_W-1:0] max_pulse;
		logic [PULSE_W-1:0] last_pulse;
		logic [CNT_W-1:0]   timeout_total;
		logic               any_fault;
		logic               last_of_run;
	} res_t;

endpackage

// ----- rtl/core/mer_dist.sv -----
// ----------------------------------------------------------------------------
// mer_dist: pulse width to distance conversion
// Converts an echo pulse width in microseconds to millimeters, truncated,
// with one constant multiply and a fixed shift in place of a divider.
// ----------------------------------------------------------------------------
module mer_dist
	import mer_pkg::*;
(
	input  logic [PULSE_W-1:0] pulse,
	output logic [DIST_W-1:0]  distance
);

	localparam int PROD_W = PULSE_W + DIST_MULT_W;

	logic [PROD_W-1:0] prod;

	// Scaled reciprocal multiply; the top bits hold the quotient.
	assign prod     = PROD_W'(pulse) * PROD_W'(DIST_MULT);
	assign distance = prod[DIST_SHIFT +: DIST_W];

endmodule

// ----- rtl/core/multichannel_echo_ranging.sv -----
// ----------------------------------------------------------------------------
// multichannel_echo_ranging: multichannel ultrasonic echo timer
// Times echo pulses on CHANNELS channels started and latched in pairs,
// converts them to distances and keeps per-channel pulse statistics.
// ----------------------------------------------------------------------------
// A transaction is taken at each clock edge with start high and busy low; one
// is taken every cycle unless busy is high: a latch of a valid group holds
// busy high for the cycle after it, and every other action leaves it low. Each
// transaction is registered, then evaluated against the channel state
// combinationally, and its results are registered in the output register,
// each shown for exactly one cycle with done high. A latch of a valid group
// gives two results on consecutive cycles (first channel of the pair, then
// the second with last_of_run set); a read gives one. The receiver cannot
// stall and must take every result in the cycle it is shown. The timeout
// register may be written only while no transaction is in flight.
// ----------------------------------------------------------------------------
module multichannel_echo_ranging
	import mer_pkg::*;
#(
	parameter int CHANNELS = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	// Command channel
	input  logic                start,
	output logic                busy,
	input  logic [ACT_W-1:0]    action,
	input  logic [2:0]          channel,
	input  logic                rise,
	input  logic                fall,
	input  logic [1:0]          group,
	input  logic                echo_level_first,
	input  logic                echo_level_second,
	// Configuration
	input  logic                cfg_we,
	input  logic [TMO_W-1:0]    cfg_wdata,
	// Result channel
	output logic                done,
	output logic [ID_W-1:0]     channel_id,
	output logic [STAT_W-1:0]   status,
	output logic [DIST_W-1:0]   distance_mm,
	output logic [CNT_W-1:0]    sample_count,
	output logic [PULSE_W-1:0]  min_pulse,
	output logic [PULSE_W-1:0]  max_pulse,
	output logic [PULSE_W-1:0]  last_pulse,
	output logic [CNT_W-1:0]    timeout_total,
	output logic                any_fault,
	output logic                last_of_run
);

	localparam int HALF = CHANNELS / 2;
	localparam int CW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	// Input register
	logic               valid_s1;
	logic [ACT_W-1:0]   action_s1;
	logic [2:0]         channel_s1;
	logic               rise_s1;
	logic               fall_s1;
	logic [1:0]         group_s1;
	logic               lvl0_s1;
	logic               lvl1_s1;

	// Channel and global state
	logic [TMO_W-1:0]   timeout_q;
	logic [TIME_W-1:0]  now_q;
	logic [CNT_W-1:0]   tmo_cnt_q;
	logic [MODE_W-1:0]  mode_q   [CHANNELS];
	logic [TIME_W-1:0]  armed_q  [CHANNELS];
	logic [TIME_W-1:0]  rise_q   [CHANNELS];
	logic [PULSE_W-1:0] pulse_q  [CHANNELS];
	logic [DIST_W-1:0]  dist_q   [CHANNELS];
	logic [STAT_W-1:0]  stat_q   [CHANNELS];
	logic [CNT_W-1:0]   cnt_q    [CHANNELS];
	logic [PULSE_W-1:0] min_q    [CHANNELS];
	logic [PULSE_W-1:0] max_q    [CHANNELS];
	logic [PULSE_W-1:0] last_q   [CHANNELS];

	// Next state
	logic [TIME_W-1:0]  now_n;
	logic [CNT_W-1:0]   tmo_cnt_n;
	logic [MODE_W-1:0]  mode_n   [CHANNELS];
	logic [TIME_W-1:0]  armed_n  [CHANNELS];
	logic [TIME_W-1:0]  rise_n   [CHANNELS];
	logic [PULSE_W-1:0] pulse_n  [CHANNELS];
	logic [DIST_W-1:0]  dist_n   [CHANNELS];
	logic [STAT_W-1:0]  stat_n   [CHANNELS];
	logic [CNT_W-1:0]   cnt_n    [CHANNELS];
	logic [PULSE_W-1:0] min_n    [CHANNELS];
	logic [PULSE_W-1:0] max_n    [CHANNELS];
	logic [PULSE_W-1:0] last_n   [CHANNELS];

	// Decoded indexes and converted distances
	logic               grp_ok;
	logic               ch_ok;
	logic [CW-1:0]      idx_a;
	logic [CW-1:0]      idx_b;
	logic [CW-1:0]      idx_ch;
	logic [DIST_W-1:0]  dist_a;
	logic [DIST_W-1:0]  dist_b;
	logic               fault_n;

	// Results
	res_t               res1;
	res_t               res2;
	logic               emit_one;
	logic               emit_two;
	res_t               out_q;
	res_t               hold_q;
	logic               done_q;
	logic               hold_vld_q;

	// A latch in the input register blocks the next transaction so that
	// its second result has the output register to itself.
	assign busy = valid_s1 && (action_s1 == ACT_LATCH) && grp_ok;

	// Input register: control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	// Input register: payload
	always_ff @(posedge clk) begin
		if (start && !busy) begin
			action_s1  <= action;
			channel_s1 <= channel;
			rise_s1    <= rise;
			fall_s1    <= fall;
			group_s1   <= group;
			lvl0_s1    <= echo_level_first;
			lvl1_s1    <= echo_level_second;
		end
	end

	// Index decode for the pair and for a single channel.
	assign grp_ok = 32'(group_s1) < HALF;
	assign ch_ok  = 32'(channel_s1) < CHANNELS;
	assign idx_a  = grp_ok ? CW'(group_s1) : '0;
	assign idx_b  = grp_ok ? CW'(32'(group_s1) + HALF) : '0;
	assign idx_ch = ch_ok ? CW'(channel_s1) : '0;

	// Distance conversion for both channels of the pair.
	mer_dist u_dist_a (
		.pulse    (pulse_q[idx_a]),
		.distance (dist_a)
	);

	mer_dist u_dist_b (
		.pulse    (pulse_q[idx_b]),
		.distance (dist_b)
	);

	// Next-state evaluation of one transaction against all channels.
	always_comb begin
		logic [TIME_W-1:0]  elapsed;
		logic [TIME_W-1:0]  width;
		logic [PULSE_W-1:0] p;
		logic               sel_a;
		logic               sel_b;
		logic               lvl;
		logic [1:0]         tmo_inc;

		elapsed   = '0;
		width     = '0;
		p         = '0;
		sel_a     = 1'b0;
		sel_b     = 1'b0;
		lvl       = 1'b0;
		now_n     = now_q;
		tmo_cnt_n = tmo_cnt_q;
		tmo_inc   = 2'd0;
		for (int c = 0; c < CHANNELS; c++) begin
			mode_n[c]  = mode_q[c];
			armed_n[c] = armed_q[c];
			rise_n[c]  = rise_q[c];
			pulse_n[c] = pulse_q[c];
			dist_n[c]  = dist_q[c];
			stat_n[c]  = stat_q[c];
			cnt_n[c]   = cnt_q[c];
			min_n[c]   = min_q[c];
			max_n[c]   = max_q[c];
			last_n[c]  = last_q[c];
		end

		if (valid_s1) begin
			case (action_s1)
				ACT_TICK: begin
					// Advance the clock and time out channels still waiting.
					now_n = now_q + TIME_W'(1);
					for (int c = 0; c < CHANNELS; c++) begin
						elapsed = now_n - armed_q[c];
						if ((mode_q[c] inside {M_WRISE, M_WFALL}) &&
						    (elapsed >= TIME_W'(timeout_q))) begin
							mode_n[c] = M_TMO;
						end
					end
				end
				ACT_EDGE: begin
					// A rise is taken before a fall in the same transaction.
					for (int c = 0; c < CHANNELS; c++) begin
						if (ch_ok && (CW'(c) == idx_ch)) begin
							if (rise_s1 && (mode_q[c] == M_WRISE)) begin
								rise_n[c] = now_q;
								mode_n[c] = M_WFALL;
							end
							if (fall_s1 && (mode_n[c] == M_WFALL)) begin
								width      = now_q - rise_n[c];
								pulse_n[c] = (width > TIME_W'(PULSE_MAX)) ?
								             PULSE_MAX : width[PULSE_W-1:0];
								mode_n[c]  = M_DONE;
							end
						end
					end
				end
				ACT_START: begin
					// Arm both channels, or mark a fault if the echo is high.
					for (int c = 0; c < CHANNELS; c++) begin
						sel_a = grp_ok && (CW'(c) == idx_a);
						sel_b = grp_ok && (CW'(c) == idx_b);
						lvl   = sel_a ? lvl0_s1 : lvl1_s1;
						if (sel_a || sel_b) begin
							if (lvl) begin
								mode_n[c] = M_FAULT;
							end else begin
								mode_n[c]  = M_WRISE;
								armed_n[c] = now_q;
							end
						end
					end
				end
				ACT_LATCH: begin
					// Turn each channel of the pair into a stored result.
					for (int c = 0; c < CHANNELS; c++) begin
						sel_a = grp_ok && (CW'(c) == idx_a);
						sel_b = grp_ok && (CW'(c) == idx_b);
						p     = pulse_q[c];
						if (sel_a || sel_b) begin
							if (mode_q[c] == M_DONE) begin
								dist_n[c] = sel_a ? dist_a : dist_b;
								stat_n[c] = S_VALID;
								last_n[c] = p;
								if (p < min_q[c]) begin
									min_n[c] = p;
								end
								if (p > max_q[c]) begin
									max_n[c] = p;
								end
								cnt_n[c] = cnt_q[c] + CNT_W'(1);
							end else if (mode_q[c] == M_FAULT) begin
								dist_n[c] = '0;
								stat_n[c] = S_FAULT;
							end else begin
								dist_n[c] = '0;
								stat_n[c] = S_TMO;
								tmo_inc   = tmo_inc + 2'd1;
							end
							mode_n[c] = M_IDLE;
						end
					end
					tmo_cnt_n = tmo_cnt_q + CNT_W'(tmo_inc);
				end
				ACT_CLEAR: begin
					for (int c = 0; c < CHANNELS; c++) begin
						cnt_n[c]  = '0;
						min_n[c]  = PULSE_MAX;
						max_n[c]  = '0;
						last_n[c] = '0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Fault summary over the updated stored status.
	always_comb begin
		fault_n = 1'b0;
		for (int c = 0; c < CHANNELS; c++) begin
			if (stat_n[c] == S_FAULT) begin
				fault_n = 1'b1;
			end
		end
	end

	// Build the result records from the updated state.
	always_comb begin
		logic [CW-1:0] i1;
		logic          ok1;

		i1  = (action_s1 == ACT_LATCH) ? idx_a : idx_ch;
		ok1 = (action_s1 == ACT_LATCH) ? grp_ok : ch_ok;

		res1.channel_id    = (action_s1 == ACT_LATCH) ? ID_W'(group_s1) : channel_s1;
		res1.status        = ok1 ? stat_n[i1] : S_FAULT;
		res1.distance_mm   = ok1 ? dist_n[i1] : '0;
		res1.sample_count  = ok1 ? cnt_n[i1] : '0;
		res1.min_pulse     = (ok1 && (cnt_n[i1] != '0)) ? min_n[i1] : '0;
		res1.max_pulse     = ok1 ? max_n[i1] : '0;
		res1.last_pulse    = ok1 ? last_n[i1] : '0;
		res1.timeout_total = tmo_cnt_n;
		res1.any_fault     = fault_n;
		res1.last_of_run   = (action_s1 != ACT_LATCH);

		res2.channel_id    = ID_W'(32'(group_s1) + HALF);
		res2.status        = stat_n[idx_b];
		res2.distance_mm   = dist_n[idx_b];
		res2.sample_count  = cnt_n[idx_b];
		res2.min_pulse     = (cnt_n[idx_b] != '0) ? min_n[idx_b] : '0;
		res2.max_pulse     = max_n[idx_b];
		res2.last_pulse    = last_n[idx_b];
		res2.timeout_total = tmo_cnt_n;
		res2.any_fault     = fault_n;
		res2.last_of_run   = 1'b1;
	end

	assign emit_two = valid_s1 && (action_s1 == ACT_LATCH) && grp_ok;
	assign emit_one = emit_two || (valid_s1 && (action_s1 == ACT_READ));

	// Channel and global state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RST;
			now_q     <= '0;
			tmo_cnt_q <= '0;
			for (int c = 0; c < CHANNELS; c++) begin
				mode_q[c]  <= M_IDLE;
				armed_q[c] <= '0;
				rise_q[c]  <= '0;
				pulse_q[c] <= '0;
				dist_q[c]  <= '0;
				stat_q[c]  <= S_TMO;
				cnt_q[c]   <= '0;
				min_q[c]   <= PULSE_MAX;
				max_q[c]   <= '0;
				last_q[c]  <= '0;
			end
		end else begin
			if (cfg_we) begin
				timeout_q <= cfg_wdata;
			end
			now_q     <= now_n;
			tmo_cnt_q <= tmo_cnt_n;
			for (int c = 0; c < CHANNELS; c++) begin
				mode_q[c]  <= mode_n[c];
				armed_q[c] <= armed_n[c];
				rise_q[c]  <= rise_n[c];
				pulse_q[c] <= pulse_n[c];
				dist_q[c]  <= dist_n[c];
				stat_q[c]  <= stat_n[c];
				cnt_q[c]   <= cnt_n[c];
				min_q[c]   <= min_n[c];
				max_q[c]   <= max_n[c];
				last_q[c]  <= last_n[c];
			end
		end
	end

	// Result strobes: first result now, a latch's second in the cycle after it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q     <= 1'b0;
			hold_vld_q <= 1'b0;
		end else begin
			done_q     <= emit_one || hold_vld_q;
			hold_vld_q <= emit_two;
		end
	end

	// Result payload registers
	always_ff @(posedge clk) begin
		if (emit_one) begin
			out_q <= res1;
		end else if (hold_vld_q) begin
			out_q <= hold_q;
		end
		if (emit_two) begin
			hold_q <= res2;
		end
	end

	assign done          = done_q;
	assign channel_id    = out_q.channel_id;
	assign status        = out_q.status;
	assign distance_mm   = out_q.distance_mm;
	assign sample_count  = out_q.sample_count;
	assign min_pulse     = out_q.min_pulse;
	assign max_pulse     = out_q.max_pulse;
	assign last_pulse    = out_q.last_pulse;
	assign timeout_total = out_q.timeout_total;
	assign any_fault     = out_q.any_fault;
	assign last_of_run   = out_q.last_of_run;

endmodule
